// ----- rtl/rkc_pkg.sv -----
`default_nettype none
package rkc_pkg;

   // fixed field widths
   localparam int PIX_W      = 8;
   localparam int TAP_COUNT  = 25;
   localparam int SUM_W      = 21;  // 25 * 128 * 255 fits with sign
   localparam int MAG_W      = 20;
   localparam int DIV_W      = 16;
   localparam int CSR_W      = 64;
   localparam int CSR_IDX_W  = 3;

   // parameter defaults
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam int DEF_MAX_KERNEL = 5;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FRAME_WIDTH  = 3'd0,
      REG_FRAME_HEIGHT = 3'd1,
      REG_KERNEL_SIZE  = 3'd2,
      REG_DIVISOR      = 3'd3,
      REG_TAPS_A       = 3'd4,
      REG_TAPS_B       = 3'd5,
      REG_TAPS_C       = 3'd6,
      REG_TAP_LAST     = 3'd7
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DRAIN,
      ST_START,
      ST_DIV,
      ST_HOLD
   } state_type;

   // accumulator control
   typedef struct packed {
      logic clear;
      logic en;
   } mac_ctl_type;

   typedef logic signed [SUM_W-1:0] sum3_type [3];
   typedef logic [PIX_W-1:0] byte3_type [3];

endpackage
`default_nettype wire

// ----- rtl/rgb_kernel_convolution_core.sv -----
`default_nettype none
// RGB 2D convolution filter on a raster pixel stream.
// req_ carries one pixel per beat in raster order; rsp_ carries one filtered
// pixel per beat for each centre whose whole k x k window lies in the frame,
// with its column and row, and tlast on the last filtered pixel of a frame.
// Border pixels give no rsp_ beat.
// csr_ writes the frame size, kernel size, divisor and taps; write only while
// no pixel is in work.
// Pixels are kept in one line-store RAM of MAX_KERNEL lines. After a pixel
// that completes no window the core is ready for the next pixel. For a pixel
// that completes a window, the window is read from the single RAM port one
// pixel a cycle and accumulated, then the three sums are divided one quotient
// bit per cycle.
// req_tready is low while a window is worked. A result waits in the output
// register while rsp_tready is low; the next pixel is still taken, and a
// second result waits in the divider until the register frees.
// Reset clears the position to column 0, row 0 and restores register
// defaults; the line store is not cleared and needs none.
module rgb_kernel_convolution_core #(
   parameter int MAX_WIDTH  = rkc_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = rkc_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_KERNEL = rkc_pkg::DEF_MAX_KERNEL
) (
   input  wire                            clock,
   input  wire                            reset,
   // red [7:0], green [15:8], blue [23:16]
   input  wire [23:0]                     req_tdata,
   input  wire                            req_tvalid,
   output logic                           req_tready,
   // red [7:0], green [15:8], blue [23:16], out_column [33:24], out_row [43:34]
   output logic [47:0]                    rsp_tdata,
   output logic                           rsp_tlast,
   output logic                           rsp_tvalid,
   input  wire                            rsp_tready,
   input  wire                            csr_we,
   input  wire [rkc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire [rkc_pkg::CSR_W-1:0]       csr_wdata
);
   import rkc_pkg::*;

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int YW = $clog2(MAX_HEIGHT);
   localparam int SW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
   localparam int AW = SW + XW;
   localparam int DEPTH = MAX_KERNEL << XW;

   // configuration, stored already clamped
   logic [XW:0]            w_ff;
   logic [YW:0]            h_ff;
   logic [2:0]             k_ff;
   logic [DIV_W-1:0]       dv_ff;
   logic signed [7:0]      taps_ff [TAP_COUNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff  <= (XW+1)'(MAX_WIDTH);
         h_ff  <= (YW+1)'(MAX_HEIGHT);
         k_ff  <= (MAX_KERNEL < 3) ? 3'(MAX_KERNEL) : 3'd3;
         dv_ff <= DIV_W'(1);
         for (int t = 0; t < TAP_COUNT; t++) begin
            taps_ff[t] <= '0;
         end
      end else if (csr_we) begin
         case (reg_index_type'(csr_index))
            REG_FRAME_WIDTH: begin
               if (csr_wdata[10:0] == 11'd0) w_ff <= (XW+1)'(1);
               else if (32'(csr_wdata[10:0]) > 32'(MAX_WIDTH)) w_ff <= (XW+1)'(MAX_WIDTH);
               else w_ff <= (XW+1)'(csr_wdata[10:0]);
            end
            REG_FRAME_HEIGHT: begin
               if (csr_wdata[10:0] == 11'd0) h_ff <= (YW+1)'(1);
               else if (32'(csr_wdata[10:0]) > 32'(MAX_HEIGHT)) h_ff <= (YW+1)'(MAX_HEIGHT);
               else h_ff <= (YW+1)'(csr_wdata[10:0]);
            end
            REG_KERNEL_SIZE: begin
               if (csr_wdata[2:0] == 3'd0) k_ff <= 3'd1;
               else if (32'(csr_wdata[2:0]) > 32'(MAX_KERNEL)) k_ff <= 3'(MAX_KERNEL);
               else k_ff <= csr_wdata[2:0];
            end
            REG_DIVISOR: begin
               dv_ff <= (csr_wdata[15:0] == 16'd0) ? DIV_W'(1) : csr_wdata[15:0];
            end
            REG_TAPS_A: for (int t = 0; t < 8; t++) taps_ff[t] <= csr_wdata[t*8 +: 8];
            REG_TAPS_B: for (int t = 0; t < 8; t++) taps_ff[8+t] <= csr_wdata[t*8 +: 8];
            REG_TAPS_C: for (int t = 0; t < 8; t++) taps_ff[16+t] <= csr_wdata[t*8 +: 8];
            REG_TAP_LAST: taps_ff[24] <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // position of the next pixel
   logic [XW-1:0] col_ff, col_in;
   logic [YW-1:0] row_ff, row_in;
   logic [SW-1:0] slot_ff, slot_in;

   logic          accept;
   logic [XW:0]   x_e;
   logic [YW:0]   y_e, y_pre;
   logic [SW-1:0] slot_pre, slot_y;
   logic [XW:0]   x_inc;
   logic [YW:0]   y_inc;
   logic          keven;
   logic [2:0]    km1;
   logic          emit, last_px;
   logic [SW:0]   start_sum;
   logic [SW-1:0] start_slot;
   logic [XW-1:0] x0;

   assign accept = req_tvalid && req_tready;
   assign keven  = ~k_ff[0];
   assign km1    = k_ff - 3'd1;

   // wrap after a size change, then step past the taken pixel
   always_comb begin
      x_e      = {1'b0, col_ff};
      y_pre    = {1'b0, row_ff};
      slot_pre = slot_ff;
      if (x_e >= w_ff) begin
         x_e      = '0;
         y_pre    = y_pre + 1'b1;
         slot_pre = (slot_ff == SW'(MAX_KERNEL - 1)) ? '0 : slot_ff + 1'b1;
      end
      y_e    = y_pre;
      slot_y = slot_pre;
      if (y_pre >= h_ff) begin
         y_e    = '0;
         slot_y = '0;
      end

      x_inc  = x_e + 1'b1;
      y_inc  = y_e + 1'b1;
      col_in = x_inc[XW-1:0];
      row_in = y_e[YW-1:0];
      slot_in = slot_y;
      if (x_inc >= w_ff) begin
         col_in  = '0;
         if (y_inc >= h_ff) begin
            row_in  = '0;
            slot_in = '0;
         end else begin
            row_in  = y_inc[YW-1:0];
            slot_in = (slot_y == SW'(MAX_KERNEL - 1)) ? '0 : slot_y + 1'b1;
         end
      end

      emit = (x_e >= (XW+1)'(km1)) && ((x_e + (XW+1)'(keven)) < w_ff) &&
             (y_e >= (YW+1)'(km1)) && ((y_e + (YW+1)'(keven)) < h_ff);
      last_px = ((x_e + 1'b1 + (XW+1)'(keven)) == w_ff) &&
                ((y_e + 1'b1 + (YW+1)'(keven)) == h_ff);

      start_sum  = {1'b0, slot_y} + (SW+1)'(MAX_KERNEL) - (SW+1)'(km1);
      start_slot = (start_sum >= (SW+1)'(MAX_KERNEL)) ?
                   SW'(start_sum - (SW+1)'(MAX_KERNEL)) : start_sum[SW-1:0];
      x0 = XW'(x_e - (XW+1)'(km1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         slot_ff <= '0;
      end else if (accept) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         slot_ff <= slot_in;
      end
   end

   // sequencer
   state_type     state_ff, state_in;
   logic [4:0]    tap_ff, tap_in;
   logic [2:0]    j_ff, j_in;
   logic [XW-1:0] rd_col_ff, rd_col_in;
   logic [SW-1:0] rd_slot_ff, rd_slot_in;
   logic [XW-1:0] x0_ff;
   logic [9:0]    ocol_ff, orow_ff;
   logic          olast_ff;
   logic          rd_valid_ff;
   logic signed [7:0] tap_d_ff;
   logic [4:0]    kk;
   logic          div_start, div_done, out_load;
   logic          rsp_valid_ff;

   assign kk       = 5'(k_ff) * 5'(k_ff);
   assign out_load = (state_ff == ST_HOLD) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in   = state_ff;
      tap_in     = tap_ff;
      j_in       = j_ff;
      rd_col_in  = rd_col_ff;
      rd_slot_in = rd_slot_ff;
      req_tready = 1'b0;
      div_start  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid && emit) begin
               state_in   = ST_READ;
               tap_in     = '0;
               j_in       = '0;
               rd_col_in  = x0;
               rd_slot_in = start_slot;
            end
         end
         ST_READ: begin
            tap_in = tap_ff + 1'b1;
            if (j_ff == km1) begin
               j_in       = '0;
               rd_col_in  = x0_ff;
               rd_slot_in = (rd_slot_ff == SW'(MAX_KERNEL - 1)) ? '0 : rd_slot_ff + 1'b1;
            end else begin
               j_in      = j_ff + 1'b1;
               rd_col_in = rd_col_ff + 1'b1;
            end
            if (tap_ff == kk - 5'd1) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_START;
         ST_START: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (out_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= (state_ff == ST_READ);
      end
      tap_ff     <= tap_in;
      j_ff       <= j_in;
      rd_col_ff  <= rd_col_in;
      rd_slot_ff <= rd_slot_in;
      tap_d_ff   <= taps_ff[tap_ff];
      if (accept) begin
         x0_ff    <= x0;
         ocol_ff  <= 10'(x_e - (XW+1)'(km1[2:1]));
         orow_ff  <= 10'(y_e - (YW+1)'(km1[2:1]));
         olast_ff <= last_px;
      end
   end

   // line store: pixel write on accept, window reads while sequencing
   logic [AW-1:0] ram_addr;
   logic [23:0]   ram_rdata;

   assign ram_addr = accept ? {slot_y, x_e[XW-1:0]} : {rd_slot_ff, rd_col_ff};

   rkc_ram #(
      .DATA_W (24),
      .ADDR_W (AW),
      .DEPTH  (DEPTH)
   ) u_line_store (
      .clock (clock),
      .we    (accept),
      .addr  (ram_addr),
      .wdata (req_tdata),
      .rdata (ram_rdata)
   );

   mac_ctl_type mac_ctl;
   sum3_type    sums;
   byte3_type   quot;

   assign mac_ctl.clear = accept && emit;
   assign mac_ctl.en    = rd_valid_ff;

   rkc_mac u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .tap   (tap_d_ff),
      .pixel (ram_rdata),
      .sums  (sums)
   );

   rkc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .sums    (sums),
      .divisor (dv_ff),
      .done    (div_done),
      .quot    (quot)
   );

   // output register
   logic [47:0] rsp_data_ff;
   logic        rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (out_load) begin
         rsp_data_ff <= {4'd0, orow_ff, ocol_ff, quot[2], quot[1], quot[0]};
         rsp_last_ff <= olast_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_read_in_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (tap_ff < kk)) else $error("read past window");
   a_emit_starts_read: assert property (@(posedge clock) disable iff (reset)
      (accept && emit) |=> (state_ff == ST_READ && !req_tready))
      else $error("window read not started");
   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || rsp_tready)) else $error("result overwritten");
   a_mac_only_reading: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> $past(state_ff == ST_READ)) else $error("stray accumulate");
endmodule
`default_nettype wire

// ----- rtl/rkc_ram.sv -----
`default_nettype none
module rkc_ram #(
   parameter int DATA_W = 24,
   parameter int ADDR_W = 12,
   parameter int DEPTH  = 4096
) (
   input  wire              clock,
   input  wire              we,
   input  wire [ADDR_W-1:0] addr,
   input  wire [DATA_W-1:0] wdata,
   output logic [DATA_W-1:0] rdata
);
   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire

// ----- rtl/rkc_mac.sv -----
`default_nettype none
module rkc_mac (
   input  wire                          clock,
   input  rkc_pkg::mac_ctl_type         ctl,
   input  wire signed [7:0]             tap,
   input  wire [23:0]                   pixel,
   output rkc_pkg::sum3_type            sums
);
   import rkc_pkg::*;

   logic signed [SUM_W-1:0] acc_ff [3];
   logic signed [SUM_W-1:0] acc_in [3];
   logic signed [16:0]      prod [3];

   // one signed tap times three unsigned channels, accumulated
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         prod[ch]   = tap * $signed({1'b0, pixel[ch*PIX_W +: PIX_W]});
         acc_in[ch] = acc_ff[ch];
         if (ctl.clear) begin
            acc_in[ch] = '0;
         end else if (ctl.en) begin
            acc_in[ch] = acc_ff[ch] + SUM_W'(prod[ch]);
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign sums = acc_ff;
endmodule
`default_nettype wire

// ----- rtl/rkc_div.sv -----
`default_nettype none
module rkc_div (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         start,
   input  rkc_pkg::sum3_type           sums,
   input  wire [rkc_pkg::DIV_W-1:0]    divisor,
   output logic                        done,
   output rkc_pkg::byte3_type          quot
);
   import rkc_pkg::*;

   localparam int CNT_W = $clog2(MAG_W + 1);

   logic [MAG_W-1:0] mag_ff [3];
   logic [MAG_W-1:0] mag_in [3];
   logic [DIV_W:0]   rem_ff [3];
   logic [DIV_W:0]   rem_in [3];
   logic [DIV_W:0]   rem_sh [3];
   logic             neg_ff [3];
   logic             neg_in [3];
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [MAG_W-1:0] q_signed [3];

   // restoring division, one quotient bit per cycle on three lanes
   always_comb begin
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      for (int ch = 0; ch < 3; ch++) begin
         mag_in[ch] = mag_ff[ch];
         rem_in[ch] = rem_ff[ch];
         neg_in[ch] = neg_ff[ch];
         rem_sh[ch] = {rem_ff[ch][DIV_W-1:0], mag_ff[ch][MAG_W-1]};
      end
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(MAG_W);
         for (int ch = 0; ch < 3; ch++) begin
            neg_in[ch] = sums[ch][SUM_W-1];
            mag_in[ch] = sums[ch][SUM_W-1] ? MAG_W'(-sums[ch]) : MAG_W'(sums[ch]);
            rem_in[ch] = '0;
         end
      end else if (busy_ff) begin
         for (int ch = 0; ch < 3; ch++) begin
            if (rem_sh[ch] >= {1'b0, divisor}) begin
               rem_in[ch] = rem_sh[ch] - {1'b0, divisor};
               mag_in[ch] = {mag_ff[ch][MAG_W-2:0], 1'b1};
            end else begin
               rem_in[ch] = rem_sh[ch];
               mag_in[ch] = {mag_ff[ch][MAG_W-2:0], 1'b0};
            end
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // sign restore, truncation toward zero
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         q_signed[ch] = neg_ff[ch] ? -mag_ff[ch] : mag_ff[ch];
         quot[ch]     = q_signed[ch][PIX_W-1:0];
      end
   end

   assign done = done_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start) else $error("divider restarted while busy");
   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider done while busy");
   a_done_after_run: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("done without a run");
endmodule
`default_nettype wire
